// ----- sv/pidc_pkg.sv -----
// Shared types, constants and width helpers for the positional PID unit.
package pidc_pkg;

	// Field widths fixed by the register map and the output format
	localparam int unsigned GAIN_W     = 24;
	localparam int unsigned LIMIT_W    = 16;
	localparam int unsigned SUM_W      = LIMIT_W + 1;
	localparam int unsigned OUT_W      = 32;
	localparam int unsigned FRAC_SHIFT = 8;
	localparam int unsigned CFG_IDX_W  = 3;

	// Default sample width
	localparam int unsigned VALUE_WIDTH_DEF = 16;

	// Register reset values
	localparam logic [GAIN_W-1:0]  KP_RESET    = 24'd3277;
	localparam logic [GAIN_W-1:0]  KI_RESET    = 24'd7;
	localparam logic [GAIN_W-1:0]  KD_RESET    = 24'd327680;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd5000;

	// Register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_KP    = 3'd0,
		CFG_KI    = 3'd1,
		CFG_KD    = 3'd2,
		CFG_LIMIT = 3'd3
	} cfg_idx_t;

	// Configuration register file contents
	typedef struct packed {
		logic [GAIN_W-1:0]  kp;
		logic [GAIN_W-1:0]  ki;
		logic [GAIN_W-1:0]  kd;
		logic [LIMIT_W-1:0] limit;
	} pidc_cfg_t;

	// Width of each registered product: gain (zero-extended, signed) times the
	// widest of derivative term and integral
	function automatic int unsigned prod_w(int unsigned vw);
		int unsigned dw;
		dw = vw + 2;
		return GAIN_W + 1 + ((dw > SUM_W) ? dw : SUM_W);
	endfunction

endpackage

// ----- sv/pidc_err_stage.sv -----
// Error, clamped integral and error difference; holds the controller state.
module pidc_err_stage #(
	parameter int unsigned VALUE_WIDTH = pidc_pkg::VALUE_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic signed [VALUE_WIDTH-1:0]        measured_value,
	input  logic signed [VALUE_WIDTH-1:0]        setpoint,
	input  logic                                 motors_stopped,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [pidc_pkg::LIMIT_W-1:0]         limit,
	input  logic                                 ready_s2,
	output logic                                 valid_s1,
	output logic signed [VALUE_WIDTH:0]          err_s1,
	output logic signed [pidc_pkg::SUM_W-1:0]    sum_s1,
	output logic signed [VALUE_WIDTH+1:0]        diff_s1
);

	localparam int unsigned ErrW  = VALUE_WIDTH + 1;
	localparam int unsigned DiffW = ErrW + 1;
	localparam int unsigned PreW  =
		((ErrW > pidc_pkg::SUM_W) ? ErrW : pidc_pkg::SUM_W) + 1;

	logic signed [ErrW-1:0]           prev_error_q;
	logic signed [pidc_pkg::SUM_W-1:0] error_sum_q;

	logic signed [ErrW-1:0]            err;
	logic signed [PreW-1:0]            pre_sum;
	logic signed [PreW-1:0]            lim_pos;
	logic signed [PreW-1:0]            lim_neg;
	logic signed [PreW-1:0]            clamped;
	logic signed [pidc_pkg::SUM_W-1:0] sum_c;
	logic signed [DiffW-1:0]           diff;
	logic                              in_acc;

	// Stage loads when empty or when its request moves on
	assign in_stall = valid_s1 && !ready_s2;
	assign in_acc   = in_valid && !in_stall;

	// Error and raw integral at full width
	assign err     = ErrW'(setpoint) - ErrW'(measured_value);
	assign pre_sum = PreW'(err) + PreW'(error_sum_q);
	assign lim_pos = signed'(PreW'({1'b0, limit}));
	assign lim_neg = -lim_pos;

	// Clamp to the configured bound
	always_comb begin
		if (pre_sum > lim_pos) begin
			clamped = lim_pos;
		end else if (pre_sum < lim_neg) begin
			clamped = lim_neg;
		end else begin
			clamped = pre_sum;
		end
	end

	assign sum_c = pidc_pkg::SUM_W'(clamped);
	assign diff  = DiffW'(err) - DiffW'(prev_error_q);

	// Controller state, updated as each request is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_error_q <= '0;
			error_sum_q  <= '0;
			valid_s1     <= 1'b0;
		end else begin
			if (in_acc) begin
				prev_error_q <= err;
				error_sum_q  <= motors_stopped ? '0 : sum_c;
			end
			if (!valid_s1 || ready_s2) begin
				valid_s1 <= in_valid;
			end
		end
	end

	// Stage payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			err_s1  <= err;
			sum_s1  <= sum_c;
			diff_s1 <= diff;
		end
	end

	// Stopped motors leave a cleared integral
	a_stop_clears: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && motors_stopped |=> error_sum_q == '0)
		else $error("integral not cleared after stopped sample");

	// Stored previous error follows the taken request
	a_prev_err: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> prev_error_q == $past(err) && err_s1 == $past(err))
		else $error("previous error not updated");

	// Integral handed on stays within the bound
	a_sum_bound: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> PreW'(sum_s1) <= $past(lim_pos) && PreW'(sum_s1) >= $past(lim_neg))
		else $error("integral outside limit");

endmodule

// ----- sv/pidc_mul_stage.sv -----
// Gain products for the proportional, integral and derivative terms.
module pidc_mul_stage #(
	parameter int unsigned VALUE_WIDTH = pidc_pkg::VALUE_WIDTH_DEF
) (
	input  logic                                                   clk,
	input  logic                                                   arst_n,
	input  pidc_pkg::pidc_cfg_t                                    cfg,
	input  logic                                                   valid_s1,
	input  logic signed [VALUE_WIDTH:0]                            err_s1,
	input  logic signed [pidc_pkg::SUM_W-1:0]                      sum_s1,
	input  logic signed [VALUE_WIDTH+1:0]                          diff_s1,
	output logic                                                   ready_s2,
	input  logic                                                   ready_s3,
	output logic                                                   valid_s2,
	output logic signed [pidc_pkg::prod_w(VALUE_WIDTH)-1:0]        kp_s2,
	output logic signed [pidc_pkg::prod_w(VALUE_WIDTH)-1:0]        ki_s2,
	output logic signed [pidc_pkg::prod_w(VALUE_WIDTH)-1:0]        kd_s2
);

	localparam int unsigned GainSW = pidc_pkg::GAIN_W + 1;
	localparam int unsigned ErrW   = VALUE_WIDTH + 1;
	localparam int unsigned ProdW  = pidc_pkg::prod_w(VALUE_WIDTH);

	logic signed [GainSW-1:0]                  kp_g;
	logic signed [GainSW-1:0]                  ki_g;
	logic signed [GainSW-1:0]                  kd_g;
	logic signed [GainSW+ErrW-1:0]             kp_full;
	logic signed [GainSW+pidc_pkg::SUM_W-1:0]  ki_full;
	logic signed [GainSW+ErrW:0]               kd_full;

	assign ready_s2 = !valid_s2 || ready_s3;

	// Unsigned gains seen as non-negative signed operands
	assign kp_g = signed'({1'b0, cfg.kp});
	assign ki_g = signed'({1'b0, cfg.ki});
	assign kd_g = signed'({1'b0, cfg.kd});

	// Three independent multipliers
	assign kp_full = kp_g * err_s1;
	assign ki_full = ki_g * sum_s1;
	assign kd_full = kd_g * diff_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			kp_s2 <= ProdW'(kp_full);
			ki_s2 <= ProdW'(ki_full);
			kd_s2 <= ProdW'(kd_full);
		end
	end

endmodule

// ----- sv/pidc_out_stage.sv -----
// Term sum, Q.8 scaling with floor, saturation and the output register.
module pidc_out_stage #(
	parameter int unsigned VALUE_WIDTH = pidc_pkg::VALUE_WIDTH_DEF
) (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  logic                                            valid_s2,
	input  logic signed [pidc_pkg::prod_w(VALUE_WIDTH)-1:0] kp_s2,
	input  logic signed [pidc_pkg::prod_w(VALUE_WIDTH)-1:0] ki_s2,
	input  logic signed [pidc_pkg::prod_w(VALUE_WIDTH)-1:0] kd_s2,
	output logic                                            ready_s3,
	output logic                                            out_valid,
	input  logic                                            out_stall,
	output logic signed [pidc_pkg::OUT_W-1:0]               drive_out
);

	localparam int unsigned ProdW = pidc_pkg::prod_w(VALUE_WIDTH);
	localparam int unsigned AccW  = ProdW + 2;
	localparam int unsigned ShW   = AccW - pidc_pkg::FRAC_SHIFT;
	localparam int unsigned OutW  = pidc_pkg::OUT_W;

	logic signed [AccW-1:0]  acc;
	logic signed [ShW-1:0]   shifted;
	logic                    ovf_pos;
	logic                    ovf_neg;
	logic signed [OutW-1:0]  sat;

	assign ready_s3 = !out_valid || !out_stall;

	// Full-width sum; dropping the low bits floors toward minus infinity
	assign acc     = AccW'(kp_s2) + AccW'(ki_s2) + AccW'(kd_s2);
	assign shifted = acc[AccW-1:pidc_pkg::FRAC_SHIFT];

	// Saturate to signed 32 bits from the bits above the output sign
	assign ovf_pos = !shifted[ShW-1] && (|shifted[ShW-2:OutW-1]);
	assign ovf_neg = shifted[ShW-1] && !(&shifted[ShW-2:OutW-1]);

	always_comb begin
		if (ovf_pos) begin
			sat = {1'b0, {(OutW-1){1'b1}}};
		end else if (ovf_neg) begin
			sat = {1'b1, {(OutW-1){1'b0}}};
		end else begin
			sat = shifted[OutW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (ready_s3) begin
			out_valid <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s3 && valid_s2) begin
			drive_out <= sat;
		end
	end

endmodule

// ----- sv/positional_pid_clamped_integral_unit.sv -----
// Positional PID, clamped integral: three-stage pipeline, one sample per clock unless stalled.
//
// A sample is taken into the first stage register at the edge that accepts it,
// and its drive_out passes through the second stage register into the output
// register; a new sample can be accepted every cycle while in_stall is low.
// The first stage forms the error and the clamped integral and updates the
// stored previous error and integral at the edge where the sample is accepted,
// so consecutive samples see each other's state. The second stage holds the
// three gain multipliers, the third the term sum, the floor shift by 8 and
// saturation to signed 32 bits. The integral is bounded by the limit register
// and cleared after a sample whose motors_stopped bit is set. Gains are
// unsigned Q16.8. Registers are written through the cfg port (always ready);
// the user must write them only while no sample is in flight; the block does
// not enforce this. Unknown indexes are ignored. An output stall holds every
// occupied stage with no empty stage after it; empty stages still fill, so
// in_stall rises only once all three stages are full and the output is stalled.
module positional_pid_clamped_integral_unit #(
	parameter int unsigned VALUE_WIDTH = pidc_pkg::VALUE_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// sample channel
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [VALUE_WIDTH-1:0]        measured_value,
	input  logic signed [VALUE_WIDTH-1:0]        setpoint,
	input  logic                                 motors_stopped,
	// result channel
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [pidc_pkg::OUT_W-1:0]    drive_out,
	// register write channel
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [pidc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [pidc_pkg::GAIN_W-1:0]          cfg_data
);

	localparam int unsigned ProdW = pidc_pkg::prod_w(VALUE_WIDTH);

	pidc_pkg::pidc_cfg_t                 cfg_q;
	logic                                valid_s1;
	logic signed [VALUE_WIDTH:0]         err_s1;
	logic signed [pidc_pkg::SUM_W-1:0]   sum_s1;
	logic signed [VALUE_WIDTH+1:0]       diff_s1;
	logic                                ready_s2;
	logic                                ready_s3;
	logic                                valid_s2;
	logic signed [ProdW-1:0]             kp_s2;
	logic signed [ProdW-1:0]             ki_s2;
	logic signed [ProdW-1:0]             kd_s2;

	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kp    <= pidc_pkg::KP_RESET;
			cfg_q.ki    <= pidc_pkg::KI_RESET;
			cfg_q.kd    <= pidc_pkg::KD_RESET;
			cfg_q.limit <= pidc_pkg::LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (pidc_pkg::cfg_idx_t'(cfg_index))
				pidc_pkg::CFG_KP: begin
					cfg_q.kp <= cfg_data;
				end
				pidc_pkg::CFG_KI: begin
					cfg_q.ki <= cfg_data;
				end
				pidc_pkg::CFG_KD: begin
					cfg_q.kd <= cfg_data;
				end
				pidc_pkg::CFG_LIMIT: begin
					cfg_q.limit <= cfg_data[pidc_pkg::LIMIT_W-1:0];
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	pidc_err_stage #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_err (
		.clk            (clk),
		.arst_n         (arst_n),
		.measured_value (measured_value),
		.setpoint       (setpoint),
		.motors_stopped (motors_stopped),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.limit          (cfg_q.limit),
		.ready_s2       (ready_s2),
		.valid_s1       (valid_s1),
		.err_s1         (err_s1),
		.sum_s1         (sum_s1),
		.diff_s1        (diff_s1)
	);

	pidc_mul_stage #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_mul (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.valid_s1 (valid_s1),
		.err_s1   (err_s1),
		.sum_s1   (sum_s1),
		.diff_s1  (diff_s1),
		.ready_s2 (ready_s2),
		.ready_s3 (ready_s3),
		.valid_s2 (valid_s2),
		.kp_s2    (kp_s2),
		.ki_s2    (ki_s2),
		.kd_s2    (kd_s2)
	);

	pidc_out_stage #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s2  (valid_s2),
		.kp_s2     (kp_s2),
		.ki_s2     (ki_s2),
		.kd_s2     (kd_s2),
		.ready_s3  (ready_s3),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.drive_out (drive_out)
	);

endmodule
